[rtl/qpb_pkg.sv]
`timescale 1ns / 1ps
package qpb_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD_MEAN   = 2'd0,
    CMD_LOAD_VAR    = 2'd1,
    CMD_LOAD_DEMAND = 2'd2,
    CMD_COMPUTE     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_ENERGY = 2'd0,
    KIND_CROSS  = 2'd1,
    KIND_QUAD   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_STANDS      = 2'd0,
    REG_TIMES       = 2'd1,
    REG_ASSORTMENTS = 2'd2,
    REG_NONE        = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_RUN  = 2'd1,
    ST_WAIT = 2'd2,
    ST_EMIT = 2'd3
  } state_t;

  localparam int unsigned AccW = 72;

  // Control handed down the row of multiply-accumulate cells.
  typedef struct packed {
    logic clear;
    logic active;
  } mac_ctl_t;

  function automatic logic [63:0] saturate(input logic signed [AccW-1:0] w);
    logic signed [63:0] lo;
    lo = w[63:0];
    if (w == AccW'(lo)) begin
      return w[63:0];
    end
    return w[AccW-1] ? 64'h8000000000000000 : 64'h7FFFFFFFFFFFFFFF;
  endfunction

endpackage

[rtl/qpb_mac_cell.sv]
`timescale 1ns / 1ps
module qpb_mac_cell (
  input  logic                              clk,
  input  qpb_pkg::mac_ctl_t                 ctl,
  input  logic signed [31:0]                a_in,
  input  logic signed [31:0]                b_in,
  input  logic signed [31:0]                v_in,
  input  logic signed [qpb_pkg::AccW-1:0]   acc_in,
  output logic signed [qpb_pkg::AccW-1:0]   acc_out
);

  logic signed [63:0] prod;
  logic signed [47:0] vsh;
  logic               act;
  logic               clr;

  // Stage one: multiply; stage two: add into the sum passed from the left.
  always_ff @(posedge clk) begin
    prod <= a_in * b_in;
    vsh  <= {v_in, 16'h0000};
    act  <= ctl.active;
    clr  <= ctl.clear;
  end

  always_ff @(posedge clk) begin
    if (act) begin
      acc_out <= (clr ? '0 : acc_in) + qpb_pkg::AccW'(prod) + qpb_pkg::AccW'(vsh);
    end else begin
      acc_out <= clr ? '0 : acc_in;
    end
  end

endmodule

[rtl/quadratic_problem_builder.sv]
`timescale 1ns / 1ps
// Channel | direction | handshake           | payload
// in      | into      | in_valid/in_ready   | command, row_index, assortment_index, operand_value
// out     | out of    | out_valid/out_ready | result_kind, out_row, out_col, out_value, last_result
// cfg     | into      | cfg_write           | cfg_index, cfg_data
// A load writes one element. A compute emits 1 + S*T + S*S results; each result
// is formed by a chain of multiply-accumulate cells, one per assortment, and
// passes through the chain before its output transfer.
// Reset (rst, synchronous) clears control and restores counts to 4.
// A stall on the output holds the sequencer; input is not taken mid-compute.
module quadratic_problem_builder #(
  parameter int MAX_STANDS      = 4,
  parameter int MAX_TIMES       = 4,
  parameter int MAX_ASSORTMENTS = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         command,
  input  logic [1:0]         row_index,
  input  logic [1:0]         assortment_index,
  input  logic signed [31:0] operand_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         result_kind,
  output logic [1:0]         out_row,
  output logic [1:0]         out_col,
  output logic signed [63:0] out_value,
  output logic               last_result,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [2:0]         cfg_data
);

  localparam int NA = MAX_ASSORTMENTS;
  localparam int LAT = NA + 1;
  localparam int LW = $clog2(LAT + 2);

  logic [2:0] n_stands, n_times, n_assort;
  logic [1:0] ns_m1, nt_m1;
  logic [3:0] na_c;

  logic signed [31:0] mean_r [MAX_STANDS][NA];
  logic signed [31:0] var_r  [MAX_STANDS][NA];
  logic signed [31:0] dem_r  [MAX_TIMES][NA];

  qpb_pkg::state_t state, state_next;
  qpb_pkg::kind_t  kind;
  logic [1:0] ri, ci;
  logic [LW-1:0] wait_cnt;
  logic in_fire, out_fire, item_last;

  // clamp the count registers
  always_comb begin
    ns_m1 = (n_stands == 3'd0) ? 2'd0 :
            (n_stands > 3'(MAX_STANDS)) ? 2'(MAX_STANDS - 1) : 2'(n_stands - 3'd1);
    nt_m1 = (n_times == 3'd0) ? 2'd0 :
            (n_times > 3'(MAX_TIMES)) ? 2'(MAX_TIMES - 1) : 2'(n_times - 3'd1);
    na_c  = (n_assort == 3'd0) ? 4'd1 :
            (4'(n_assort) > 4'(NA)) ? 4'(NA) : 4'(n_assort);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n_stands <= 3'd4;
      n_times  <= 3'd4;
      n_assort <= 3'd4;
    end else if (cfg_write) begin
      unique case (qpb_pkg::reg_idx_t'(cfg_index))
        qpb_pkg::REG_STANDS:      n_stands <= cfg_data;
        qpb_pkg::REG_TIMES:       n_times  <= cfg_data;
        qpb_pkg::REG_ASSORTMENTS: n_assort <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ready = (state == qpb_pkg::ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // Loads: write one element, drop out-of-range indices.
  always_ff @(posedge clk) begin
    if (in_fire && 32'(assortment_index) < 32'(NA)) begin
      unique case (qpb_pkg::cmd_t'(command))
        qpb_pkg::CMD_LOAD_MEAN:
          if (32'(row_index) < 32'(MAX_STANDS))
            mean_r[row_index][assortment_index] <= operand_value;
        qpb_pkg::CMD_LOAD_VAR:
          if (32'(row_index) < 32'(MAX_STANDS))
            var_r[row_index][assortment_index] <= operand_value;
        qpb_pkg::CMD_LOAD_DEMAND:
          if (32'(row_index) < 32'(MAX_TIMES))
            dem_r[row_index][assortment_index] <= operand_value;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (kind)
      qpb_pkg::KIND_ENERGY: item_last = (ri == nt_m1);
      qpb_pkg::KIND_CROSS:  item_last = 1'b0;
      default:              item_last = (ri == ns_m1) && (ci == ns_m1);
    endcase
  end

  // Sequencer: issue one item into the cell chain, wait, emit (energy rows accumulate first).
  always_comb begin
    state_next = state;
    unique case (state)
      qpb_pkg::ST_IDLE:
        if (in_fire && command == qpb_pkg::CMD_COMPUTE) state_next = qpb_pkg::ST_RUN;
      qpb_pkg::ST_RUN:  state_next = qpb_pkg::ST_WAIT;
      qpb_pkg::ST_WAIT:
        // enter emit exactly in the cycle the chain output is valid
        if (wait_cnt == LW'(LAT - 2)) state_next = qpb_pkg::ST_EMIT;
      qpb_pkg::ST_EMIT:
        if (out_fire) state_next = last_result ? qpb_pkg::ST_IDLE : qpb_pkg::ST_RUN;
        else if (out_valid) state_next = qpb_pkg::ST_EMIT;
        else state_next = (kind == qpb_pkg::KIND_ENERGY && !item_last) ?
                          qpb_pkg::ST_RUN : qpb_pkg::ST_EMIT;
      default: state_next = qpb_pkg::ST_IDLE;
    endcase
  end

  // energy r is accumulated over time rows; keep a running wide sum
  logic signed [qpb_pkg::AccW-1:0] energy_acc;
  logic signed [qpb_pkg::AccW-1:0] chain [NA+1];
  logic signed [31:0] a_op [NA];
  logic signed [31:0] b_op [NA];
  logic signed [31:0] v_op [NA];
  qpb_pkg::mac_ctl_t ctl [NA];
  logic issue;

  assign issue = (state == qpb_pkg::ST_RUN);
  assign chain[0] = '0;

  genvar g;
  generate
    for (g = 0; g < NA; g++) begin : g_cell
      always_comb begin
        ctl[g].clear  = 1'b0;
        ctl[g].active = issue && (4'(g) < na_c);
        v_op[g] = '0;
        unique case (kind)
          qpb_pkg::KIND_ENERGY: begin
            a_op[g] = dem_r[ri][g];
            b_op[g] = dem_r[ri][g];
          end
          qpb_pkg::KIND_CROSS: begin
            a_op[g] = mean_r[ri][g];
            b_op[g] = dem_r[ci][g];
          end
          default: begin
            a_op[g] = mean_r[ri][g];
            b_op[g] = mean_r[ci][g];
            if (ri == ci) v_op[g] = var_r[ri][g];
          end
        endcase
      end
      // Operands are presented together; the sum ripples one cell per cycle,
      // so the operands of cell g are held back by a small delay line to meet the sum.
      logic signed [31:0] ad [g+1];
      logic signed [31:0] bd [g+1];
      logic signed [31:0] vd [g+1];
      qpb_pkg::mac_ctl_t  cd [g+1];
      assign ad[0] = a_op[g];
      assign bd[0] = b_op[g];
      assign vd[0] = v_op[g];
      assign cd[0] = ctl[g];
      for (genvar k = 1; k <= g; k++) begin : g_dly
        always_ff @(posedge clk) begin
          ad[k] <= ad[k-1];
          bd[k] <= bd[k-1];
          vd[k] <= vd[k-1];
          cd[k] <= rst ? '0 : cd[k-1];
        end
      end
      qpb_mac_cell u_cell (
        .clk    (clk),
        .ctl    (cd[g]),
        .a_in   (ad[g]),
        .b_in   (bd[g]),
        .v_in   (vd[g]),
        .acc_in (chain[g]),
        .acc_out(chain[g+1])
      );
    end
  endgenerate

  // chain output is valid for one cycle; align to the issue by counter
  logic signed [qpb_pkg::AccW-1:0] sum_w, fin;
  assign sum_w = chain[NA];

  always_comb begin
    unique case (kind)
      qpb_pkg::KIND_ENERGY: fin = energy_acc + sum_w;
      qpb_pkg::KIND_CROSS:  fin = -(sum_w <<< 1);
      default:              fin = sum_w <<< 1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= qpb_pkg::ST_IDLE;
      out_valid <= 1'b0;
      wait_cnt  <= '0;
      kind      <= qpb_pkg::KIND_ENERGY;
      ri        <= '0;
      ci        <= '0;
    end else begin
      state <= state_next;
      if (state == qpb_pkg::ST_IDLE && in_fire && command == qpb_pkg::CMD_COMPUTE) begin
        kind <= qpb_pkg::KIND_ENERGY;
        ri <= '0;
        ci <= '0;
        energy_acc <= '0;
      end
      if (state == qpb_pkg::ST_RUN) wait_cnt <= '0;
      else if (state == qpb_pkg::ST_WAIT) wait_cnt <= wait_cnt + LW'(1);
      if (state == qpb_pkg::ST_EMIT && !out_valid) begin
        if (kind == qpb_pkg::KIND_ENERGY && !item_last) begin
          energy_acc <= fin;
          ri <= ri + 2'd1;
        end else begin
          out_valid   <= 1'b1;
          result_kind <= kind;
          out_row     <= (kind == qpb_pkg::KIND_ENERGY) ? 2'd0 : ri;
          out_col     <= (kind == qpb_pkg::KIND_ENERGY) ? 2'd0 : ci;
          out_value   <= qpb_pkg::saturate(fin);
          last_result <= (kind == qpb_pkg::KIND_QUAD) && item_last;
        end
      end
      if (out_fire) begin
        out_valid <= 1'b0;
        // advance to the next entry
        unique case (kind)
          qpb_pkg::KIND_ENERGY: begin
            kind <= qpb_pkg::KIND_CROSS;
            ri <= '0;
            ci <= '0;
          end
          qpb_pkg::KIND_CROSS:
            if (ci == nt_m1) begin
              ci <= '0;
              if (ri == ns_m1) begin
                kind <= qpb_pkg::KIND_QUAD;
                ri <= '0;
              end else ri <= ri + 2'd1;
            end else ci <= ci + 2'd1;
          default:
            if (ci == ns_m1) begin
              ci <= '0;
              ri <= ri + 2'd1;
            end else ci <= ci + 2'd1;
        endcase
      end
    end
  end

  property p_no_in_busy;
    @(posedge clk) disable iff (rst) (state != qpb_pkg::ST_IDLE) |-> !in_ready;
  endproperty
  a_no_in_busy: assert property (p_no_in_busy) else $error("input taken while busy");

  a_last_quad: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_result) |-> (result_kind == qpb_pkg::KIND_QUAD))
    else $error("last flag off a quad entry");

  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (out_fire && last_result) |=> (state == qpb_pkg::ST_IDLE))
    else $error("sequencer did not return idle");

endmodule
